// ----- sv/pcssa_pkg.sv -----
// pcssa_pkg: shared types and constants of the per-cpu stack slot allocator
// no dependencies; used by per_cpu_stack_slot_allocator_top
package pcssa_pkg;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STS_ALLOCATED     = 2'd0,
    STS_OUT_OF_SLOTS  = 2'd1,
    STS_FREED_LOCAL   = 2'd2,
    STS_FREE_DEFERRED = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_e;

  // register index as decoded from the apb address
  typedef enum logic [0:0] {
    REG_STACK_TOP  = 1'b0,
    REG_SIZE_LOG2  = 1'b1
  } reg_e;

  localparam int AddrW      = 48;
  localparam int SizeLog2W  = 5;
  localparam int PaddrW     = 4;
  localparam int PdataW     = 64;
  localparam int RegSelBit  = 3;

  localparam logic [AddrW-1:0]     StackTopRst = '0;
  localparam logic [SizeLog2W-1:0] SizeLog2Rst = 5'd12;
  localparam logic [AddrW-1:0]     RedZone     = 48'd8;

  typedef struct packed {
    cmd_e       command;
    logic [1:0] domain;
    logic [2:0] cpu;
    logic [2:0] owner_cpu;
    logic [2:0] slot;
  } in_item_t;

  typedef struct packed {
    status_e          status;
    logic [2:0]       granted_slot;
    logic [AddrW-1:0] stack_address;
  } out_item_t;

endpackage

// ----- sv/pcssa_ram.sv -----
// pcssa_ram: generic single-write, single-read ram with registered read data
// no dependencies
module pcssa_ram #(
  parameter int Width = 8,
  parameter int Depth = 32,
  parameter int AW    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- sv/per_cpu_stack_slot_allocator_top.sv -----
// per_cpu_stack_slot_allocator_top: stack slot allocator with deferred remote free
// depends on pcssa_pkg and pcssa_ram
//
// One table entry per (domain, cpu) pair holds the free map, the deferred-free
// map and the pending flag, all in a single ram word. An item is handled in an
// accept cycle and an execute cycle: in the accept cycle the entry index drives
// the ram read address, and in the following execute cycle the registered word
// is modified, written back and the result is loaded into the output register.
// The next item is taken only after that write, so items never overlap; the
// ram read is registered ahead of the read-modify-write. When the output register
// still holds an untaken result, the execute cycle waits until it is taken.
// Reset needs no clearing pass: a per-entry valid bit in flip-flops marks entries
// never written, which read as all slots free with nothing deferred.
// Configuration sits on a 64-bit apb port: stack_region_top at byte 0x0,
// stack_size_log2 at byte 0x8 (address bit 3 selects the register).
module per_cpu_stack_slot_allocator_top #(
  parameter int SLOTS_PER_CPU = 8,
  parameter int NUM_CPUS      = 8,
  parameter int NUM_DOMAINS   = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  pcssa_pkg::in_item_t             in_item_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output pcssa_pkg::out_item_t            out_item_o,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pcssa_pkg::PaddrW-1:0]    paddr,
  input  logic [pcssa_pkg::PdataW-1:0]    pwdata,
  output logic [pcssa_pkg::PdataW-1:0]    prdata,
  output logic                            pready
);

  localparam int Entries = NUM_DOMAINS * NUM_CPUS;
  localparam int EW      = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int S       = SLOTS_PER_CPU;
  localparam int BW      = (S > 1) ? $clog2(S) : 1;
  localparam int WordW   = 2 * S + 1;
  // slot offset cpu*(S+1)+bit stays below 8*(S+1)
  localparam int MW      = $clog2(8 * (S + 1)) + 1;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [pcssa_pkg::AddrW-1:0]     stack_top_q;
  logic [pcssa_pkg::SizeLog2W-1:0] size_log2_q;
  pcssa_pkg::reg_e                 reg_sel;
  logic                            cfg_we;

  assign pready  = 1'b1;
  assign reg_sel = pcssa_pkg::reg_e'(paddr[pcssa_pkg::RegSelBit]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_top_q <= pcssa_pkg::StackTopRst;
      size_log2_q <= pcssa_pkg::SizeLog2Rst;
    end else if (cfg_we) begin
      case (reg_sel)
        pcssa_pkg::REG_STACK_TOP: stack_top_q <= pwdata[pcssa_pkg::AddrW-1:0];
        pcssa_pkg::REG_SIZE_LOG2: size_log2_q <= pwdata[pcssa_pkg::SizeLog2W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      pcssa_pkg::REG_STACK_TOP:
        prdata = pcssa_pkg::PdataW'(stack_top_q);
      pcssa_pkg::REG_SIZE_LOG2:
        prdata = pcssa_pkg::PdataW'(size_log2_q);
      default:
        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // request capture and entry lookup
  // ---------------------------------------------------------------------------
  pcssa_pkg::fsm_e     state_q, state_d;
  pcssa_pkg::in_item_t item_q;
  logic                in_accept;
  logic                proceed;

  assign in_stall_o = (state_q != pcssa_pkg::FSM_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // alloc works on the requesting cpu, free on the owner
  function automatic logic [EW-1:0] entry_of(pcssa_pkg::in_item_t it);
    logic [2:0] c;
    c = (it.command == pcssa_pkg::CMD_ALLOC) ? it.cpu : it.owner_cpu;
    return EW'(int'(it.domain) * NUM_CPUS + int'(c));
  endfunction

  logic [EW-1:0] rd_idx;
  logic [EW-1:0] idx_q;

  // the read address holds on the captured item during execute so the
  // registered word stays put while the output waits
  assign rd_idx = in_accept ? entry_of(in_item_i) : idx_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_item_i;
      idx_q  <= entry_of(in_item_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcssa_pkg::FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pcssa_pkg::FSM_IDLE: begin
        if (in_accept) begin
          state_d = pcssa_pkg::FSM_EXEC;
        end
      end
      pcssa_pkg::FSM_EXEC: begin
        if (proceed) begin
          state_d = pcssa_pkg::FSM_IDLE;
        end
      end
      default: state_d = pcssa_pkg::FSM_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // entry table: {pending, deferred map, free map}
  // ---------------------------------------------------------------------------
  logic [WordW-1:0]   ram_rdata;
  logic [WordW-1:0]   ram_wdata;
  logic               ram_we;
  logic [Entries-1:0] valid_q;

  pcssa_ram #(
    .Width (WordW),
    .Depth (Entries),
    .AW    (EW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .raddr_i (rd_idx),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ram_we) begin
      valid_q[idx_q] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // execute: modify the entry and form the result
  // ---------------------------------------------------------------------------
  logic                 out_valid_q;
  pcssa_pkg::out_item_t out_q;
  pcssa_pkg::out_item_t res;

  logic [S-1:0]  free_map, defer_map;
  logic          pending;
  logic [S-1:0]  new_free, new_defer;
  logic          new_pending;
  logic [BW-1:0] low_bit;
  logic          found;
  logic          alloc_ok;
  logic          free_ok;
  logic          is_local;
  logic          need_wr;
  logic [S-1:0]  slot_mask;
  logic [MW-1:0] slot_ofs;
  logic [pcssa_pkg::AddrW-1:0] slot_size;
  logic [pcssa_pkg::AddrW-1:0] ofs_bytes;

  assign proceed = (state_q == pcssa_pkg::FSM_EXEC) && (!out_valid_q || !out_stall_i);

  always_comb begin
    // never-written entries read as reset contents
    if (valid_q[idx_q]) begin
      {pending, defer_map, free_map} = ram_rdata;
    end else begin
      pending   = 1'b0;
      defer_map = '0;
      free_map  = '1;
    end

    // lowest free slot
    found   = 1'b0;
    low_bit = '0;
    for (int i = S - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        found   = 1'b1;
        low_bit = BW'(i);
      end
    end

    alloc_ok  = (int'(item_q.domain) < NUM_DOMAINS) && (int'(item_q.cpu) < NUM_CPUS);
    free_ok   = (int'(item_q.domain) < NUM_DOMAINS) && (int'(item_q.owner_cpu) < NUM_CPUS)
                && (int'(item_q.slot) < S);
    is_local  = (item_q.cpu == item_q.owner_cpu);
    slot_mask = S'(1) << item_q.slot;

    slot_ofs  = MW'(item_q.cpu) * MW'(S + 1) + MW'(low_bit);
    slot_size = pcssa_pkg::AddrW'(1) << size_log2_q;
    ofs_bytes = pcssa_pkg::AddrW'(slot_ofs) << size_log2_q;

    new_free    = free_map;
    new_defer   = defer_map;
    new_pending = pending;
    need_wr     = 1'b0;

    res.status        = pcssa_pkg::STS_OUT_OF_SLOTS;
    res.granted_slot  = '0;
    res.stack_address = '0;

    case (item_q.command)
      pcssa_pkg::CMD_ALLOC: begin
        if (alloc_ok) begin
          need_wr = 1'b1;
          if (found) begin
            new_free[low_bit] = 1'b0;
            res.status        = pcssa_pkg::STS_ALLOCATED;
            res.granted_slot  = 3'(low_bit);
            res.stack_address = stack_top_q - ofs_bytes + slot_size - pcssa_pkg::RedZone;
          end
          // merged frees show up from the next alloc on
          if (pending) begin
            new_free    = new_free | defer_map;
            new_defer   = '0;
            new_pending = 1'b0;
          end
        end
      end
      pcssa_pkg::CMD_FREE: begin
        res.status = is_local ? pcssa_pkg::STS_FREED_LOCAL : pcssa_pkg::STS_FREE_DEFERRED;
        if (free_ok) begin
          need_wr = 1'b1;
          if (is_local) begin
            new_free = free_map | slot_mask;
          end else begin
            new_defer   = defer_map | slot_mask;
            new_pending = 1'b1;
          end
        end
      end
      default: ;
    endcase

    ram_wdata = {new_pending, new_defer, new_free};
    ram_we    = proceed && need_wr;
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proceed) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proceed) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_result_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == pcssa_pkg::FSM_EXEC))
    else $error("result appeared without an execute cycle");

  a_no_grant_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != pcssa_pkg::STS_ALLOCATED)
      |-> (out_item_o.granted_slot == '0) && (out_item_o.stack_address == '0))
    else $error("slot or address set on a non-grant result");

  a_entry_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> valid_q[$past(idx_q)])
    else $error("written entry not marked valid");

  a_one_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == pcssa_pkg::FSM_EXEC) && !in_accept)
    else $error("item taken while another is in execute");

endmodule
